### design/button_press_release_hold_detector_unit_macros.svh
// assertion macros used by the checker file
`ifndef BUTTON_PRESS_RELEASE_HOLD_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_PRESS_RELEASE_HOLD_DETECTOR_UNIT_MACROS_SVH

// condition now implies consequence in the next cycle
`define BPRHD_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the same cycle
`define BPRHD_ASSERT_NOW(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

`endif

### design/bprhd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprhd_pkg
// Types and constants of the button press, release and hold detector.
// ----------------------------------------------------------------------------
package bprhd_pkg;

   localparam int MAX_CH = 16;
   localparam int CH_W = 4;
   localparam int WORD_W = 16;
   localparam int TIMER_W = 16;
   localparam logic [TIMER_W-1:0] HOLD_TICKS_RESET = 16'd1000;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [1:0] EV_PRESS = 2'd0;
   localparam logic [1:0] EV_RELEASE = 2'd1;
   localparam logic [1:0] EV_HOLD = 2'd2;

   typedef struct packed {
      logic              func;
      logic [WORD_W-1:0] status_word;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic [1:0]      event_kind;
      logic            last_event;
   } rsp_type;

   // one channel's state and inputs as seen by the update unit
   typedef struct packed {
      logic               func;
      logic               lvl_now;
      logic               lvl_was;
      logic               first;
      logic [TIMER_W-1:0] timer;
      logic               running;
      logic               reported;
      logic [TIMER_W-1:0] hold_ticks;
   } chan_in_type;

   typedef struct packed {
      logic               emit;
      logic [1:0]         kind;
      logic [TIMER_W-1:0] timer;
      logic               running;
      logic               reported;
   } chan_upd_type;

endpackage

### design/button_press_release_hold_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_release_hold_detector_unit
// Press, release and hold detector for up to 16 button channels.
// ----------------------------------------------------------------------------
// Each item is a status word or a 1 ms tick. A single channel update unit
// visits the active channels, min(CHANNELS,16) of them, one per clock
// unless the result side stalls; a flush state then hands over the final
// event and the block returns to idle. Events come out in ascending channel
// order, the final one of an item marked by last_event. req_ready is low
// while an item is at work. hold_ticks is written through the csr port
// while idle.
// ----------------------------------------------------------------------------
module button_press_release_hold_detector_unit #(
   parameter int CHANNELS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bprhd_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bprhd_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bprhd_pkg::TIMER_W-1:0]     csr_wdata
);

   localparam int ACTIVE = (CHANNELS < bprhd_pkg::MAX_CH) ? CHANNELS : bprhd_pkg::MAX_CH;
   localparam int IDX_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              cnt_ff, cnt_in;
   bprhd_pkg::req_type            item_ff, item_in;
   logic [bprhd_pkg::TIMER_W-1:0] hold_ticks_ff, hold_ticks_in;
   logic [bprhd_pkg::WORD_W-1:0]  last_levels_ff, last_levels_in;
   logic                          first_ff, first_in;
   logic [bprhd_pkg::TIMER_W-1:0] timer_ff [ACTIVE];
   logic [bprhd_pkg::TIMER_W-1:0] timer_in [ACTIVE];
   logic [ACTIVE-1:0]             running_ff, running_in;
   logic [ACTIVE-1:0]             reported_ff, reported_in;
   bprhd_pkg::rsp_type            pend_ff, pend_in;
   logic                          pend_valid_ff, pend_valid_in;
   bprhd_pkg::rsp_type            rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   bprhd_pkg::chan_in_type        chan_in;
   bprhd_pkg::chan_upd_type       chan_upd;
   logic                          out_free;
   logic                          stall;
   logic [bprhd_pkg::CH_W-1:0]    ch_idx;

   assign ch_idx = bprhd_pkg::CH_W'(cnt_ff);

   assign chan_in.func = item_ff.func;
   assign chan_in.lvl_now = item_ff.status_word[ch_idx];
   assign chan_in.lvl_was = last_levels_ff[ch_idx];
   assign chan_in.first = first_ff;
   assign chan_in.timer = timer_ff[cnt_ff];
   assign chan_in.running = running_ff[cnt_ff];
   assign chan_in.reported = reported_ff[cnt_ff];
   assign chan_in.hold_ticks = hold_ticks_ff;

   bprhd_chan_unit u_chan (
      .chan_in  (chan_in),
      .chan_upd (chan_upd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   // a second event needs the output register before the pending one moves
   assign stall = chan_upd.emit && pend_valid_ff && !out_free;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      item_in = item_ff;
      hold_ticks_in = hold_ticks_ff;
      last_levels_in = last_levels_ff;
      first_in = first_ff;
      timer_in = timer_ff;
      running_in = running_ff;
      reported_in = reported_ff;
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid && csr_ready) begin
         hold_ticks_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               cnt_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!stall) begin
               timer_in[cnt_ff] = chan_upd.timer;
               running_in[cnt_ff] = chan_upd.running;
               reported_in[cnt_ff] = chan_upd.reported;
               if (chan_upd.emit) begin
                  if (pend_valid_ff) begin
                     rsp_in = pend_ff;
                     rsp_in.last_event = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in.channel = ch_idx;
                  pend_in.event_kind = chan_upd.kind;
                  pend_in.last_event = 1'b0;
                  pend_valid_in = 1'b1;
               end
               if (cnt_ff == IDX_W'(ACTIVE - 1)) begin
                  if (item_ff.func == bprhd_pkg::FUNC_SAMPLE) begin
                     last_levels_in = item_ff.status_word;
                     first_in = 1'b0;
                  end
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in = pend_ff;
               rsp_in.last_event = 1'b1;
               rsp_valid_in = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         hold_ticks_ff <= bprhd_pkg::HOLD_TICKS_RESET;
         last_levels_ff <= '0;
         first_ff <= 1'b1;
         running_ff <= '0;
         reported_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ACTIVE; i++) begin
            timer_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         hold_ticks_ff <= hold_ticks_in;
         last_levels_ff <= last_levels_in;
         first_ff <= first_in;
         running_ff <= running_in;
         reported_ff <= reported_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

endmodule

### design/bprhd_chan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprhd_chan_unit
// Shared per-channel update: timer advance and threshold compare on a tick,
// edge detection and hold-mark handling on a status word.
// ----------------------------------------------------------------------------
module bprhd_chan_unit (
   input  bprhd_pkg::chan_in_type  chan_in,
   output bprhd_pkg::chan_upd_type chan_upd
);

   logic [bprhd_pkg::TIMER_W-1:0] timer_inc;

   // saturating increment
   assign timer_inc = (chan_in.timer == '1) ? chan_in.timer
                                            : chan_in.timer + 1'b1;

   always_comb begin
      chan_upd.emit = 1'b0;
      chan_upd.kind = bprhd_pkg::EV_PRESS;
      chan_upd.timer = chan_in.timer;
      chan_upd.running = chan_in.running;
      chan_upd.reported = chan_in.reported;
      if (chan_in.func == bprhd_pkg::FUNC_TICK) begin
         if (chan_in.running) begin
            if (timer_inc >= chan_in.hold_ticks) begin
               chan_upd.emit = 1'b1;
               chan_upd.kind = bprhd_pkg::EV_HOLD;
               chan_upd.timer = '0;
               chan_upd.running = 1'b0;
               chan_upd.reported = 1'b1;
            end else begin
               chan_upd.timer = timer_inc;
            end
         end
      end else if (chan_in.first || (chan_in.lvl_now != chan_in.lvl_was)) begin
         chan_upd.running = chan_in.lvl_now;
         chan_upd.timer = '0;
         if (chan_in.reported) begin
            // change after a hold is swallowed
            chan_upd.reported = 1'b0;
         end else begin
            chan_upd.emit = 1'b1;
            chan_upd.kind = chan_in.lvl_now ? bprhd_pkg::EV_PRESS
                                            : bprhd_pkg::EV_RELEASE;
         end
      end
   end

endmodule

### design/bprhd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprhd_checker
// Port-level checks of the button press, release and hold detector.
// ----------------------------------------------------------------------------
`include "button_press_release_hold_detector_unit_macros.svh"

module bprhd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bprhd_pkg::rsp_type rsp_data
);

   // a result waiting for the sink stays offered
   `BPRHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one item at a time: after an accept the block is busy
   `BPRHD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // only press, release and hold are ever reported
   `BPRHD_ASSERT_NOW(a_kind_legal, clock, reset, rsp_valid, rsp_data.event_kind == bprhd_pkg::EV_PRESS || rsp_data.event_kind == bprhd_pkg::EV_RELEASE || rsp_data.event_kind == bprhd_pkg::EV_HOLD)

endmodule

bind button_press_release_hold_detector_unit bprhd_checker u_bprhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
